// ----- rtl/core/gf256_vandermonde_shard_encoder_unit_assert.svh -----
// Assertion macros for the shard encoder.
`ifndef GF256_VANDERMONDE_SHARD_ENCODER_UNIT_ASSERT_SVH
`define GF256_VANDERMONDE_SHARD_ENCODER_UNIT_ASSERT_SVH

// Same-cycle implication under synchronous active-low reset.
`define GFVSE_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
    else $error("gfvse assertion failed");

// Next-cycle implication under synchronous active-low reset.
`define GFVSE_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
    else $error("gfvse assertion failed");

`endif

// ----- rtl/core/gfvse_pkg.sv -----
// Shared types, constants and GF(2^8) multiply for the shard encoder.
`timescale 1ns / 1ps
package gfvse_pkg;

  localparam int SHARDS = 12;
  localparam int SHARD_IDX_W = 4;
  localparam int CHUNK_BYTES_DEF = 8;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam logic [8:0] GF_POLY = 9'h11D;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 64;
  localparam logic [CFG_IDX_W-1:0] CFG_POINTS_FIRST_EIGHT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POINTS_LAST_FOUR = 2'd1;

  localparam logic [63:0] POINTS_FIRST_EIGHT_RST = 64'h0807060504030201;
  localparam logic [31:0] POINTS_LAST_FOUR_RST = 32'h0C0B0A09;

  typedef logic [SHARDS-1:0][7:0] point_vec_t;

  typedef struct packed {
    logic [7:0] data;
    logic       flush;
  } q_word_t;

  // Shift-and-add multiply, reduced by the field polynomial each step.
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] x;
    logic [7:0] r;
    x = {1'b0, a};
    r = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        r = r ^ x[7:0];
      end
      x = {x[7:0], 1'b0};
      if (x[8]) begin
        x = x ^ GF_POLY;
      end
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/gfvse_front.sv -----
// Front end: accepts data words, counts chunk position, tags chunk-ending words.
`timescale 1ns / 1ps
module gfvse_front import gfvse_pkg::*; #(
  parameter int CHUNK_BYTES = CHUNK_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_data,
  input  logic       q_full,
  output logic       q_push,
  output q_word_t    q_push_word
);

  localparam int CNT_W = $clog2(CHUNK_BYTES + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W:0]   cnt_inc;
  logic             ends_chunk;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  assign cnt_inc    = {1'b0, cnt_r} + (CNT_W + 1)'(1);
  assign ends_chunk = in_end_of_data || (cnt_inc >= (CNT_W + 1)'(CHUNK_BYTES));

  assign q_push_word.data  = in_data_byte;
  assign q_push_word.flush = ends_chunk;

  always_comb begin
    cnt_nxt = cnt_r;
    if (q_push) begin
      cnt_nxt = ends_chunk ? '0 : cnt_inc[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- rtl/core/gfvse_queue.sv -----
// Short word queue between front end and evaluation back end.
`timescale 1ns / 1ps
module gfvse_queue import gfvse_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  q_word_t push_word,
  output logic    full,
  input  logic    pop,
  output logic    valid,
  output q_word_t pop_word
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_word_t          mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign valid    = (cnt_r != '0);
  assign pop_word = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ----- rtl/core/gfvse_back.sv -----
// Back end: twelve GF(2^8) evaluation lanes and the result bank that drains them.
`timescale 1ns / 1ps
module gfvse_back import gfvse_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  input  q_word_t                q_word,
  output logic                   q_pop,
  input  point_vec_t             points,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SHARD_IDX_W-1:0] out_shard_index,
  output logic [7:0]             out_shard_byte,
  output logic                   out_last_of_chunk
);

  logic [7:0] acc_r  [SHARDS];
  logic [7:0] acc_nxt[SHARDS];
  logic [7:0] pow_r  [SHARDS];
  logic [7:0] pow_nxt[SHARDS];
  logic [7:0] mix    [SHARDS];
  logic [7:0] bank_r [SHARDS];

  logic                   busy_r, busy_nxt;
  logic [SHARD_IDX_W-1:0] idx_r, idx_nxt;
  logic                   load_bank;

  // A flush word needs a free bank, or one whose last shard leaves this cycle;
  // ordinary words always go.
  assign q_pop     = q_valid && (!q_word.flush || !busy_r ||
                                 (out_ready && out_last_of_chunk));
  assign load_bank = q_pop && q_word.flush;

  always_comb begin
    for (int n = 0; n < SHARDS; n++) begin
      mix[n]     = acc_r[n] ^ gf_mul(q_word.data, pow_r[n]);
      acc_nxt[n] = acc_r[n];
      pow_nxt[n] = pow_r[n];
      if (q_pop) begin
        if (q_word.flush) begin
          acc_nxt[n] = 8'h00;
          pow_nxt[n] = 8'h01;
        end else begin
          acc_nxt[n] = mix[n];
          pow_nxt[n] = gf_mul(pow_r[n], points[n]);
        end
      end
    end
  end

  assign out_valid         = busy_r;
  assign out_shard_index   = idx_r;
  assign out_shard_byte    = bank_r[idx_r];
  assign out_last_of_chunk = (idx_r == SHARD_IDX_W'(SHARDS - 1));

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (busy_r && out_ready) begin
      if (out_last_of_chunk) begin
        busy_nxt = 1'b0;
        idx_nxt  = '0;
      end else begin
        idx_nxt = idx_r + SHARD_IDX_W'(1);
      end
    end
    if (load_bank) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_bank) begin
      for (int n = 0; n < SHARDS; n++) begin
        bank_r[n] <= mix[n];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
      for (int n = 0; n < SHARDS; n++) begin
        acc_r[n] <= 8'h00;
        pow_r[n] <= 8'h01;
      end
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
      for (int n = 0; n < SHARDS; n++) begin
        acc_r[n] <= acc_nxt[n];
        pow_r[n] <= pow_nxt[n];
      end
    end
  end

endmodule

// ----- rtl/core/gf256_vandermonde_shard_encoder_unit.sv -----
// Top level of the GF(2^8) Vandermonde shard encoder.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-------------------------------------
//   in_     | in        | in_valid/in_ready   | data_byte[7:0], end_of_data
//   out_    | out       | out_valid/out_ready | shard_index[3:0], shard_byte[7:0],
//           |           |                     | last_of_chunk
//   cfg_    | in        | cfg_valid/cfg_ready | index[1:0], data[63:0]
//
// Rates: one input word per cycle into the queue while in_ready is high; the back
//   end folds one queued word per cycle into all twelve lanes (a flush word waits
//   for a free bank); twelve results leave a bank at one per cycle while out_ready
//   is high. A chunk-ending word is queued, then loads the bank, sending shard 0 first.
// Reset: synchronous, active low; clears lanes and counters, loads reset points.
// Stalls: out_ready low holds the bank; the back end keeps folding the next chunk
//   until its flush word finds the bank busy, then the queue fills and in_ready drops.
`timescale 1ns / 1ps
`include "gf256_vandermonde_shard_encoder_unit_assert.svh"
module gf256_vandermonde_shard_encoder_unit import gfvse_pkg::*; #(
  parameter int CHUNK_BYTES = CHUNK_BYTES_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             in_data_byte,
  input  logic                   in_end_of_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SHARD_IDX_W-1:0] out_shard_index,
  output logic [7:0]             out_shard_byte,
  output logic                   out_last_of_chunk,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // Evaluation point registers; writes beyond index 1 are dropped.
  logic [63:0] points_first_eight_r, points_first_eight_nxt;
  logic [31:0] points_last_four_r, points_last_four_nxt;
  point_vec_t  points;

  q_word_t push_word, pop_word;
  logic    q_push, q_pop, q_full, q_valid;

  assign cfg_ready = 1'b1;

  always_comb begin
    points_first_eight_nxt = points_first_eight_r;
    points_last_four_nxt   = points_last_four_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_POINTS_FIRST_EIGHT: points_first_eight_nxt = cfg_data;
        CFG_POINTS_LAST_FOUR:   points_last_four_nxt   = cfg_data[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      points_first_eight_r <= POINTS_FIRST_EIGHT_RST;
      points_last_four_r   <= POINTS_LAST_FOUR_RST;
    end else begin
      points_first_eight_r <= points_first_eight_nxt;
      points_last_four_r   <= points_last_four_nxt;
    end
  end

  // Shard 0 in the low byte of the first register, shard 8 in the low byte of the second.
  assign points = {points_last_four_r, points_first_eight_r};

  gfvse_front #(
    .CHUNK_BYTES(CHUNK_BYTES)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_byte  (in_data_byte),
    .in_end_of_data(in_end_of_data),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_push_word   (push_word)
  );

  gfvse_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_word(push_word),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .pop_word (pop_word)
  );

  gfvse_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_word           (pop_word),
    .q_pop            (q_pop),
    .points           (points),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_shard_index  (out_shard_index),
    .out_shard_byte   (out_shard_byte),
    .out_last_of_chunk(out_last_of_chunk)
  );

  // A flush word taken by the back end opens a fresh burst at shard 0.
  `GFVSE_ASSERT_NEXT(a_flush_starts_burst, clk, rst_n, q_pop && pop_word.flush,
                     out_valid && (out_shard_index == '0))
  // Shard indices never run past the last shard.
  `GFVSE_ASSERT_NOW(a_index_range, clk, rst_n, out_valid,
                    out_shard_index <= SHARD_IDX_W'(SHARDS - 1))
  // After the last shard goes, either the bank is empty or a new burst starts at 0.
  `GFVSE_ASSERT_NEXT(a_burst_end, clk, rst_n, out_valid && out_ready && out_last_of_chunk,
                     !out_valid || (out_shard_index == '0))

endmodule
